>>> src/s2c_pkg.sv
package s2c_pkg;

    localparam int CordicStagesDef = 24;
    localparam int AtanEntries     = 30;

    // Widths inside the sine/cosine unit.
    localparam int AngW  = 32;
    localparam int RedW  = 36;
    localparam int CorW  = 34;
    localparam int TrigW = 32;

    localparam int DataW = 32;
    localparam int OutW  = 48;
    localparam int SumW  = 52;

    localparam logic signed [RedW-1:0] Q30Pi     = 36'sd3373259426;
    localparam logic signed [RedW-1:0] Q30TwoPi  = 36'sd6746518852;
    localparam logic signed [RedW-1:0] Q30HalfPi = 36'sd1686629713;
    localparam logic signed [CorW-1:0] Q30Gain   = 34'sd652032874;

    localparam logic signed [SumW-1:0] OutMax = SumW'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SumW-1:0] OutMin = -SumW'(48'sh7FFF_FFFF_FFFF) - 52'sd1;

    typedef struct packed {
        logic signed [OutW-1:0] value;
        logic                   clamped;
    } t_sat;

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic logic signed [CorW-1:0] f_atan(input int idx);
        logic signed [CorW-1:0] v;
        case (idx)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            default: v = (idx < AtanEntries) ? (34'sd1 <<< (30 - idx)) : 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_sat f_sat(input logic signed [SumW-1:0] v);
        t_sat s;
        if (v > OutMax) begin
            s.value   = OutMax[OutW-1:0];
            s.clamped = 1'b1;
        end else if (v < OutMin) begin
            s.value   = OutMin[OutW-1:0];
            s.clamped = 1'b1;
        end else begin
            s.value   = v[OutW-1:0];
            s.clamped = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> src/s2c_delay.sv
module s2c_delay #(
    parameter int W = 32,
    parameter int D = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_d,
    output logic signed [W-1:0] o_q
);

    logic signed [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[D-1];

endmodule

>>> src/s2c_mulr.sv
// Signed multiply, scaled down by 2^SHIFT with rounding half away from zero.
// Four stages: magnitudes, two partial products, sum and round, sign.
module s2c_mulr #(
    parameter int WA    = 32,
    parameter int WB    = 32,
    parameter int SHIFT = 30,
    parameter int WO    = 34
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WA-1:0] i_a,
    input  logic signed [WB-1:0] i_b,
    output logic signed [WO-1:0] o_p
);

    localparam int LO = WA / 2;
    localparam int HI = WA - LO;
    localparam int PW = WA + WB;
    localparam logic [PW-1:0] Rnd = PW'(1) << (SHIFT - 1);

    logic [WA-1:0]    n_am, r_am;
    logic [WB-1:0]    n_bm, r_bm;
    logic [LO+WB-1:0] r_pl;
    logic [HI+WB-1:0] r_ph;
    logic [PW-1:0]    n_sum, r_mag;
    logic             r_neg1, r_neg2, r_neg3;
    logic signed [WO-1:0] r_p;

    always_comb begin
        n_am  = i_a[WA-1] ? WA'(-i_a) : WA'(i_a);
        n_bm  = i_b[WB-1] ? WB'(-i_b) : WB'(i_b);
        n_sum = (PW'(r_ph) << LO) + PW'(r_pl) + Rnd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am   <= n_am;
            r_bm   <= n_bm;
            r_neg1 <= i_a[WA-1] ^ i_b[WB-1];
            r_pl   <= (LO+WB)'(r_am[LO-1:0]) * (LO+WB)'(r_bm);
            r_ph   <= (HI+WB)'(r_am[WA-1:LO]) * (HI+WB)'(r_bm);
            r_neg2 <= r_neg1;
            r_mag  <= n_sum >> SHIFT;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? WO'(-r_mag) : WO'(r_mag);
        end
    end

    assign o_p = r_p;

endmodule

>>> src/s2c_trig.sv
// Cosine and sine of a Q3.28 angle in Q30: two reduction stages,
// one CORDIC rotation per stage, then the quadrant sign.
module s2c_trig #(
    parameter int CORDIC_STAGES = s2c_pkg::CordicStagesDef
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [s2c_pkg::AngW-1:0]     i_ang,
    output logic signed [s2c_pkg::TrigW-1:0]    o_cos,
    output logic signed [s2c_pkg::TrigW-1:0]    o_sin
);

    localparam int RedW = s2c_pkg::RedW;
    localparam int CorW = s2c_pkg::CorW;
    localparam int TrigW = s2c_pkg::TrigW;

    logic signed [RedW-1:0] n_z4, n_wrap, r_wrap, n_fold;
    logic                   n_flip;

    logic signed [CorW-1:0] r_x [CORDIC_STAGES+1];
    logic signed [CorW-1:0] r_y [CORDIC_STAGES+1];
    logic signed [CorW-1:0] r_z [CORDIC_STAGES+1];
    logic                   r_flip [CORDIC_STAGES+1];

    logic signed [TrigW-1:0] r_cos, r_sin;

    always_comb begin
        n_z4 = RedW'(i_ang) <<< 2;
        if (n_z4 > s2c_pkg::Q30Pi) begin
            n_wrap = n_z4 - s2c_pkg::Q30TwoPi;
        end else if (n_z4 < -s2c_pkg::Q30Pi) begin
            n_wrap = n_z4 + s2c_pkg::Q30TwoPi;
        end else begin
            n_wrap = n_z4;
        end
        // Beyond a quarter turn, rotate by a half turn and negate both results.
        if (r_wrap > s2c_pkg::Q30HalfPi) begin
            n_fold = r_wrap - s2c_pkg::Q30Pi;
            n_flip = 1'b1;
        end else if (r_wrap < -s2c_pkg::Q30HalfPi) begin
            n_fold = r_wrap + s2c_pkg::Q30Pi;
            n_flip = 1'b1;
        end else begin
            n_fold = r_wrap;
            n_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wrap    <= n_wrap;
            r_x[0]    <= s2c_pkg::Q30Gain;
            r_y[0]    <= '0;
            r_z[0]    <= CorW'(n_fold);
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - s2c_pkg::f_atan(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + s2c_pkg::f_atan(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[CORDIC_STAGES] ? TrigW'(-r_x[CORDIC_STAGES])
                                           : TrigW'(r_x[CORDIC_STAGES]);
            r_sin <= r_flip[CORDIC_STAGES] ? TrigW'(-r_y[CORDIC_STAGES])
                                           : TrigW'(r_y[CORDIC_STAGES]);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> src/spherical_to_cartesian_pv.sv
// Throughput: one transaction per cycle while the output is not stalled; the depth is set
// by the reduction, CORDIC rotation and sign stages of the trig units, three rounds of
// four-stage multipliers, the sum registers and the output register.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears only the valid bits; data is not reset.
module spherical_to_cartesian_pv #(
    parameter int CORDIC_STAGES = s2c_pkg::CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_longitude,
    input  logic signed [31:0] i_latitude,
    input  logic signed [31:0] i_radial_distance,
    input  logic signed [31:0] i_longitude_rate,
    input  logic signed [31:0] i_latitude_rate,
    input  logic signed [31:0] i_distance_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [47:0] o_pos_x,
    output logic signed [47:0] o_pos_y,
    output logic signed [47:0] o_pos_z,
    output logic signed [47:0] o_vel_x,
    output logic signed [47:0] o_vel_y,
    output logic signed [47:0] o_vel_z,
    output logic               o_saturated
);

    localparam int LT  = CORDIC_STAGES + 3;
    localparam int LAT = LT + 15;
    localparam int SumW = s2c_pkg::SumW;

    logic en;
    logic [LAT-1:0] r_vld;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Trig values, aligned with the delayed scalar inputs.
    logic signed [31:0] clon, slon, clat, slat;
    logic signed [31:0] r_t0, dlat_t0, dr_t0, dlong_t3;

    s2c_trig #(.CORDIC_STAGES(CORDIC_STAGES)) u_lon (
        .i_clk(i_clk), .i_en(en), .i_ang(i_longitude), .o_cos(clon), .o_sin(slon));
    s2c_trig #(.CORDIC_STAGES(CORDIC_STAGES)) u_lat (
        .i_clk(i_clk), .i_en(en), .i_ang(i_latitude), .o_cos(clat), .o_sin(slat));

    s2c_delay #(.W(32), .D(LT)) u_dr (
        .i_clk(i_clk), .i_en(en), .i_d(i_radial_distance), .o_q(r_t0));
    s2c_delay #(.W(32), .D(LT)) u_ddlat (
        .i_clk(i_clk), .i_en(en), .i_d(i_latitude_rate), .o_q(dlat_t0));
    s2c_delay #(.W(32), .D(LT)) u_ddr (
        .i_clk(i_clk), .i_en(en), .i_d(i_distance_rate), .o_q(dr_t0));
    s2c_delay #(.W(32), .D(LT + 9)) u_ddlong (
        .i_clk(i_clk), .i_en(en), .i_d(i_longitude_rate), .o_q(dlong_t3));

    // First round of products.
    logic signed [33:0] rcl, z_t1, p_cd, p_sd;
    logic signed [47:0] rdlat;

    s2c_mulr #(.WA(32), .WB(32), .SHIFT(30), .WO(34)) u_m_rcl (
        .i_clk(i_clk), .i_en(en), .i_a(r_t0), .i_b(clat), .o_p(rcl));
    s2c_mulr #(.WA(32), .WB(32), .SHIFT(30), .WO(34)) u_m_z (
        .i_clk(i_clk), .i_en(en), .i_a(r_t0), .i_b(slat), .o_p(z_t1));
    s2c_mulr #(.WA(32), .WB(32), .SHIFT(16), .WO(48)) u_m_rdl (
        .i_clk(i_clk), .i_en(en), .i_a(r_t0), .i_b(dlat_t0), .o_p(rdlat));
    s2c_mulr #(.WA(32), .WB(32), .SHIFT(30), .WO(34)) u_m_cd (
        .i_clk(i_clk), .i_en(en), .i_a(dr_t0), .i_b(clat), .o_p(p_cd));
    s2c_mulr #(.WA(32), .WB(32), .SHIFT(30), .WO(34)) u_m_sd (
        .i_clk(i_clk), .i_en(en), .i_a(dr_t0), .i_b(slat), .o_p(p_sd));

    logic signed [31:0] clon_t1, slon_t1, clat_t1, slat_t1, clon_t3, slon_t3;

    s2c_delay #(.W(32), .D(4)) u_dclon1 (
        .i_clk(i_clk), .i_en(en), .i_d(clon), .o_q(clon_t1));
    s2c_delay #(.W(32), .D(4)) u_dslon1 (
        .i_clk(i_clk), .i_en(en), .i_d(slon), .o_q(slon_t1));
    s2c_delay #(.W(32), .D(4)) u_dclat1 (
        .i_clk(i_clk), .i_en(en), .i_d(clat), .o_q(clat_t1));
    s2c_delay #(.W(32), .D(4)) u_dslat1 (
        .i_clk(i_clk), .i_en(en), .i_d(slat), .o_q(slat_t1));
    s2c_delay #(.W(32), .D(5)) u_dclon3 (
        .i_clk(i_clk), .i_en(en), .i_d(clon_t1), .o_q(clon_t3));
    s2c_delay #(.W(32), .D(5)) u_dslon3 (
        .i_clk(i_clk), .i_en(en), .i_d(slon_t1), .o_q(slon_t3));

    // Second round.
    logic signed [33:0] x_t2, y_t2, p_cd_t2, p_sd_t2;
    logic signed [47:0] p_rs, p_rc;

    s2c_mulr #(.WA(34), .WB(32), .SHIFT(30), .WO(34)) u_m_x (
        .i_clk(i_clk), .i_en(en), .i_a(rcl), .i_b(clon_t1), .o_p(x_t2));
    s2c_mulr #(.WA(34), .WB(32), .SHIFT(30), .WO(34)) u_m_y (
        .i_clk(i_clk), .i_en(en), .i_a(rcl), .i_b(slon_t1), .o_p(y_t2));
    s2c_mulr #(.WA(48), .WB(32), .SHIFT(30), .WO(48)) u_m_rs (
        .i_clk(i_clk), .i_en(en), .i_a(rdlat), .i_b(slat_t1), .o_p(p_rs));
    s2c_mulr #(.WA(48), .WB(32), .SHIFT(30), .WO(48)) u_m_rc (
        .i_clk(i_clk), .i_en(en), .i_a(rdlat), .i_b(clat_t1), .o_p(p_rc));

    s2c_delay #(.W(34), .D(4)) u_dcd (
        .i_clk(i_clk), .i_en(en), .i_d(p_cd), .o_q(p_cd_t2));
    s2c_delay #(.W(34), .D(4)) u_dsd (
        .i_clk(i_clk), .i_en(en), .i_d(p_sd), .o_q(p_sd_t2));

    logic signed [48:0] r_w, r_vz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w  <= 49'(p_rs) - 49'(p_cd_t2);
            r_vz <= 49'(p_rc) + 49'(p_sd_t2);
        end
    end

    logic signed [33:0] x_t3, y_t3;

    s2c_delay #(.W(34), .D(1)) u_dx1 (
        .i_clk(i_clk), .i_en(en), .i_d(x_t2), .o_q(x_t3));
    s2c_delay #(.W(34), .D(1)) u_dy1 (
        .i_clk(i_clk), .i_en(en), .i_d(y_t2), .o_q(y_t3));

    // Third round: velocity terms.
    logic signed [49:0] p_ydl, p_xdl, p_wc, p_ws;

    s2c_mulr #(.WA(34), .WB(32), .SHIFT(16), .WO(50)) u_m_ydl (
        .i_clk(i_clk), .i_en(en), .i_a(y_t3), .i_b(dlong_t3), .o_p(p_ydl));
    s2c_mulr #(.WA(34), .WB(32), .SHIFT(16), .WO(50)) u_m_xdl (
        .i_clk(i_clk), .i_en(en), .i_a(x_t3), .i_b(dlong_t3), .o_p(p_xdl));
    s2c_mulr #(.WA(49), .WB(32), .SHIFT(30), .WO(50)) u_m_wc (
        .i_clk(i_clk), .i_en(en), .i_a(r_w), .i_b(clon_t3), .o_p(p_wc));
    s2c_mulr #(.WA(49), .WB(32), .SHIFT(30), .WO(50)) u_m_ws (
        .i_clk(i_clk), .i_en(en), .i_a(r_w), .i_b(slon_t3), .o_p(p_ws));

    logic signed [SumW-1:0] r_vx, r_vy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx <= -SumW'(p_ydl) - SumW'(p_wc);
            r_vy <= SumW'(p_xdl) - SumW'(p_ws);
        end
    end

    logic signed [33:0] x_t5, y_t5, z_t5;
    logic signed [48:0] vz_t5;

    s2c_delay #(.W(34), .D(5)) u_dx5 (
        .i_clk(i_clk), .i_en(en), .i_d(x_t3), .o_q(x_t5));
    s2c_delay #(.W(34), .D(5)) u_dy5 (
        .i_clk(i_clk), .i_en(en), .i_d(y_t3), .o_q(y_t5));
    s2c_delay #(.W(34), .D(10)) u_dz5 (
        .i_clk(i_clk), .i_en(en), .i_d(z_t1), .o_q(z_t5));
    s2c_delay #(.W(49), .D(5)) u_dvz5 (
        .i_clk(i_clk), .i_en(en), .i_d(r_vz), .o_q(vz_t5));

    // Clamp and output register.
    s2c_pkg::t_sat s_x, s_y, s_z, s_vx, s_vy, s_vz;
    logic signed [47:0] r_pos_x, r_pos_y, r_pos_z, r_vel_x, r_vel_y, r_vel_z;
    logic               r_sat;

    always_comb begin
        s_x  = s2c_pkg::f_sat(SumW'(x_t5));
        s_y  = s2c_pkg::f_sat(SumW'(y_t5));
        s_z  = s2c_pkg::f_sat(SumW'(z_t5));
        s_vx = s2c_pkg::f_sat(r_vx);
        s_vy = s2c_pkg::f_sat(r_vy);
        s_vz = s2c_pkg::f_sat(SumW'(vz_t5));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos_x <= s_x.value;
            r_pos_y <= s_y.value;
            r_pos_z <= s_z.value;
            r_vel_x <= s_vx.value;
            r_vel_y <= s_vy.value;
            r_vel_z <= s_vz.value;
            r_sat   <= s_x.clamped | s_y.clamped | s_z.clamped
                     | s_vx.clamped | s_vy.clamped | s_vz.clamped;
        end
    end

    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_pos_z     = r_pos_z;
    assign o_vel_x     = r_vel_x;
    assign o_vel_y     = r_vel_y;
    assign o_vel_z     = r_vel_z;
    assign o_saturated = r_sat;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int Stages   = s2c_pkg::CordicStagesDef;
    localparam int Latency  = Stages + 18;
    localparam int NumRand  = 1130;
    localparam int HoldLen  = 300;

    localparam longint PiQ30     = 64'sd3373259426;
    localparam longint TwoPiQ30  = 64'sd6746518852;
    localparam longint HalfPiQ30 = 64'sd1686629713;
    localparam longint GainQ30   = 64'sd652032874;
    localparam longint PosLimit  = 64'sd140737488355327;
    localparam longint NegLimit  = -64'sd140737488355328;

    typedef struct {
        logic signed [s2c_pkg::DataW-1:0] lon;
        logic signed [s2c_pkg::DataW-1:0] lat;
        logic signed [s2c_pkg::DataW-1:0] rad;
        logic signed [s2c_pkg::DataW-1:0] lon_rate;
        logic signed [s2c_pkg::DataW-1:0] lat_rate;
        logic signed [s2c_pkg::DataW-1:0] rad_rate;
    } t_sph;

    typedef struct {
        logic signed [s2c_pkg::OutW-1:0] px;
        logic signed [s2c_pkg::OutW-1:0] py;
        logic signed [s2c_pkg::OutW-1:0] pz;
        logic signed [s2c_pkg::OutW-1:0] vx;
        logic signed [s2c_pkg::OutW-1:0] vy;
        logic signed [s2c_pkg::OutW-1:0] vz;
        logic                            sat;
    } t_cart;

    typedef struct {
        t_sph  coord;
        bit    known;
        t_cart result;
    } t_row;

    localparam t_cart Zero = '{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 1'b0};
    localparam logic signed [31:0] Mx = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Mn = 32'sh8000_0000;
    localparam logic signed [31:0] Hp = 32'sd421657428;   // pi/2 in Q3.28
    localparam logic signed [31:0] Pi = 32'sd843314857;   // pi in Q3.28

    localparam int NumDir = 16;
    t_row dir_tab [NumDir] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, Zero},
        '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{Mx, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{Mn, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{32'sd0, Mx, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{32'sd0, Mn, 32'sd65536, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{Hp, -Hp, Mx, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{Pi, Hp, Mn, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{-Pi, Pi, Mx, 32'sd0, 32'sd0, 32'sd0}, 1'b0, Zero},
        '{'{Hp + 1, -Hp - 1, 32'sd65536, Mx, Mn, Mx}, 1'b0, Zero},
        '{'{32'sd1000, 32'sd2000, 32'sd65536, Mn, Mx, Mn}, 1'b0, Zero},
        '{'{Mx, Mx, Mx, Mx, Mx, Mx}, 1'b0, Zero},
        '{'{Mn, Mn, Mn, Mn, Mn, Mn}, 1'b0, Zero},
        '{'{32'sd300000000, 32'sd100000000, Mx, Mx, Mx, Mx}, 1'b0, Zero},
        '{'{-32'sd300000000, 32'sd100000000, Mn, Mn, Mx, Mn}, 1'b0, Zero},
        '{'{32'sd12345, -32'sd54321, 32'sd7, -32'sd3, 32'sd5, -32'sd1}, 1'b0, Zero}
    };

    longint atan_tab [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_saturated;
    logic signed [31:0] i_longitude = '0, i_latitude = '0, i_radial_distance = '0;
    logic signed [31:0] i_longitude_rate = '0, i_latitude_rate = '0, i_distance_rate = '0;
    logic signed [47:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;

    t_cart cart_expected [$];
    bit    cur_known = 1'b0;
    t_cart cur_result = Zero;
    int    errors = 0;
    int    items_in = 0;
    int    results_out = 0;
    int    sat_seen = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    spherical_to_cartesian_pv u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_longitude, .i_latitude, .i_radial_distance,
        .i_longitude_rate, .i_latitude_rate, .i_distance_rate,
        .o_valid, .i_ready,
        .o_pos_x, .o_pos_y, .o_pos_z, .o_vel_x, .o_vel_y, .o_vel_z, .o_saturated
    );

    // Sine and cosine in Q30 from a Q3.28 angle, by rotation-mode CORDIC.
    task automatic trig_q30(input longint ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z = ang * 4;
        x = GainQ30;
        y = 0;
        flip = 1'b0;
        while (z > PiQ30) z -= TwoPiQ30;
        while (z < -PiQ30) z += TwoPiQ30;
        if (z > HalfPiQ30) begin
            z -= PiQ30;
            flip = 1'b1;
        end else if (z < -HalfPiQ30) begin
            z += PiQ30;
            flip = 1'b1;
        end
        for (int i = 0; i < Stages && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Product scaled down by 2^sh, rounded half away from zero.
    function automatic longint scaled_mul(longint a, longint b, int sh);
        logic [127:0] ua, ub, m;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        m = (ua * ub + (128'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic signed [47:0] clamp48(longint v, inout logic flag);
        if (v > PosLimit) begin
            flag = 1'b1;
            return PosLimit[47:0];
        end else if (v < NegLimit) begin
            flag = 1'b1;
            return NegLimit[47:0];
        end
        return v[47:0];
    endfunction

    task automatic to_cartesian(input t_sph p, output t_cart q);
        longint r, dlon, dlat, dr, clon, slon, clat, slat;
        longint rcl, x, y, z, rdlat, w, vx, vy, vz;
        logic   flag;
        r = p.rad;
        dlon = p.lon_rate;
        dlat = p.lat_rate;
        dr = p.rad_rate;
        flag = 1'b0;
        trig_q30(longint'(p.lon), clon, slon);
        trig_q30(longint'(p.lat), clat, slat);
        rcl = scaled_mul(r, clat, 30);
        x = scaled_mul(rcl, clon, 30);
        y = scaled_mul(rcl, slon, 30);
        z = scaled_mul(r, slat, 30);
        rdlat = scaled_mul(r, dlat, 16);
        w = scaled_mul(rdlat, slat, 30) - scaled_mul(clat, dr, 30);
        vx = -scaled_mul(y, dlon, 16) - scaled_mul(w, clon, 30);
        vy = scaled_mul(x, dlon, 16) - scaled_mul(w, slon, 30);
        vz = scaled_mul(rdlat, clat, 30) + scaled_mul(slat, dr, 30);
        q.px = clamp48(x, flag);
        q.py = clamp48(y, flag);
        q.pz = clamp48(z, flag);
        q.vx = clamp48(vx, flag);
        q.vy = clamp48(vy, flag);
        q.vz = clamp48(vz, flag);
        q.sat = flag;
    endtask

    // Input side: work out the expected result for each accepted transaction.
    always @(posedge i_clk) begin
        t_sph  p;
        t_cart q;
        if (i_rst_n && i_valid && o_ready) begin
            p = '{i_longitude, i_latitude, i_radial_distance,
                  i_longitude_rate, i_latitude_rate, i_distance_rate};
            if (cur_known) q = cur_result;
            else to_cartesian(p, q);
            cart_expected.push_back(q);
            items_in++;
        end
    end

    // Output side: compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_cart e;
        if (i_rst_n && o_valid && i_ready) begin
            results_out++;
            if (o_saturated) sat_seen++;
            if (cart_expected.size() == 0) begin
                $display("%0t: unexpected result, nothing outstanding", $realtime);
                errors++;
            end else begin
                e = cart_expected.pop_front();
                if (o_pos_x !== e.px) begin
                    $display("%0t: pos_x exp %0d got %0d", $realtime, e.px, o_pos_x);
                    errors++;
                end
                if (o_pos_y !== e.py) begin
                    $display("%0t: pos_y exp %0d got %0d", $realtime, e.py, o_pos_y);
                    errors++;
                end
                if (o_pos_z !== e.pz) begin
                    $display("%0t: pos_z exp %0d got %0d", $realtime, e.pz, o_pos_z);
                    errors++;
                end
                if (o_vel_x !== e.vx) begin
                    $display("%0t: vel_x exp %0d got %0d", $realtime, e.vx, o_vel_x);
                    errors++;
                end
                if (o_vel_y !== e.vy) begin
                    $display("%0t: vel_y exp %0d got %0d", $realtime, e.vy, o_vel_y);
                    errors++;
                end
                if (o_vel_z !== e.vz) begin
                    $display("%0t: vel_z exp %0d got %0d", $realtime, e.vz, o_vel_z);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated exp %0b got %0b", $realtime, e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && held < HoldLen) begin
                i_ready <= 1'b0;
                held++;
            end else begin
                i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
            end
        end
    end

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 2) != 0) v = v >>> $urandom_range(0, 31);
        return v;
    endfunction

    task automatic send(input t_sph p, input bit known, input t_cart res);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_longitude <= p.lon;
        i_latitude <= p.lat;
        i_radial_distance <= p.rad;
        i_longitude_rate <= p.lon_rate;
        i_latitude_rate <= p.lat_rate;
        i_distance_rate <= p.rad_rate;
        cur_known <= known;
        cur_result <= res;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_sph p;
        int   wait_cnt;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int k = 0; k < NumDir; k++) send(dir_tab[k].coord, dir_tab[k].known, dir_tab[k].result);
        for (int k = 0; k < NumRand; k++) begin
            calm = (k >= 400 && k < 600);
            if (k == 700) hold_req = 1'b1;
            p.lon = $urandom;
            p.lat = $urandom;
            p.rad = rand_word();
            p.lon_rate = rand_word();
            p.lat_rate = rand_word();
            p.rad_rate = rand_word();
            send(p, 1'b0, Zero);
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        wait_cnt = 0;
        while (cart_expected.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (Latency + 20) @(posedge i_clk);
        if (cart_expected.size() != 0) begin
            $display("%0d results never arrived", cart_expected.size());
            errors++;
        end
        $display("Converted %0d coordinate sets (directed extremes, wrapped angles, random)",
                 items_in);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_out, sat_seen, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timed out waiting for the block");
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/s2c_pkg.sv
src/s2c_delay.sv
src/s2c_mulr.sv
src/s2c_trig.sv
src/spherical_to_cartesian_pv.sv
bench/tb_top.sv
